[rtl/core/trs_pkg.sv]
// types and constants shared by the tabulated rejection sampler
package trs_pkg;

    localparam int COORD_BITS = 16;
    localparam int RAND_BITS  = 16;
    localparam int INDEX_BITS = 8;
    localparam int PTS_BITS   = 9;
    localparam int OPER_BITS  = (COORD_BITS > RAND_BITS) ? COORD_BITS : RAND_BITS;
    localparam int PROD_BITS  = 2 * OPER_BITS;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_TRIAL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_LOAD_DONE = 2'd0,
        ST_ACCEPT    = 2'd1,
        ST_REJECT    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_MUL_X,
        S_MUL_Y,
        S_SCAN,
        S_NEXT,
        S_LHS,
        S_RHS,
        S_FINISH
    } state_t;

    typedef struct packed {
        op_t                   op;
        logic [INDEX_BITS-1:0] point_index;
        logic [COORD_BITS-1:0] x_value;
        logic [COORD_BITS-1:0] y_value;
        logic [RAND_BITS-1:0]  rand_x;
        logic [RAND_BITS-1:0]  rand_y;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        logic [COORD_BITS-1:0] sample_x;
    } out_item_t;

endpackage

[rtl/core/trs_table.sv]
// point table memory: one write port, one registered read port
module trs_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [trs_pkg::COORD_BITS-1:0] wr_x,
    input  logic [trs_pkg::COORD_BITS-1:0] wr_y,
    input  logic [AW-1:0]                  rd_addr,
    output logic [trs_pkg::COORD_BITS-1:0] rd_x,
    output logic [trs_pkg::COORD_BITS-1:0] rd_y
);
    import trs_pkg::*;

    logic [2*COORD_BITS-1:0] mem [DEPTH];
    logic [2*COORD_BITS-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_x = rd_reg[2*COORD_BITS-1:COORD_BITS];
    assign rd_y = rd_reg[COORD_BITS-1:0];

endmodule

[rtl/core/trs_mul.sv]
// shared unsigned multiplier with registered product
module trs_mul (
    input  logic                          clk,
    input  logic [trs_pkg::OPER_BITS-1:0] a,
    input  logic [trs_pkg::OPER_BITS-1:0] b,
    output logic [trs_pkg::PROD_BITS-1:0] prod
);
    import trs_pkg::*;

    logic [PROD_BITS-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_BITS'(a) * PROD_BITS'(b);
    end

    assign prod = prod_reg;

endmodule

[rtl/core/tabulated_rejection_sampler.sv]
// Tabulated rejection sampler: a load item writes one (x, y) point into the table and
// updates the running maximum weight. A trial item runs a downward segment scan of s table
// entries and, unless the chosen segment has no positive width, two cross products, where
// s = n-1-j for a chosen segment j >= 1 and s = n-1 when the first segment is chosen
// (n = points in use). The scan reads one table entry per cycle through the single read
// port of the table memory; the span scaling, weight scaling and the two cross products share
// one 16x16 multiplier. The result sits in an output register, and the next item is taken
// once the result has moved there. No clearing pass is run after reset: table entries must
// be loaded before a trial reads them.
module tabulated_rejection_sampler #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [trs_pkg::PTS_BITS-1:0] cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  trs_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output trs_pkg::out_item_t           out_data
);
    import trs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    state_t                 state_reg, state_next;
    logic [PTS_BITS-1:0]    points_reg;
    logic [COORD_BITS-1:0]  max_reg, max_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [RAND_BITS-1:0]   rx_reg, rx_next;
    logic [RAND_BITS-1:0]   ry_reg, ry_next;
    logic [COORD_BITS-1:0]  f_reg, f_next;
    logic [COORD_BITS-1:0]  xc_reg, xc_next;
    logic [COORD_BITS-1:0]  yc_reg, yc_next;
    logic [COORD_BITS-1:0]  xj_reg, xj_next;
    logic [COORD_BITS-1:0]  yj_reg, yj_next;
    logic                   lneg_reg, lneg_next;
    logic                   dy_neg_reg, dy_neg_next;
    logic                   dxc_neg_reg, dxc_neg_next;
    logic [OPER_BITS-1:0]   dy_mag_reg, dy_mag_next;
    logic [OPER_BITS-1:0]   dxc_mag_reg, dxc_mag_next;
    logic [PROD_BITS-1:0]   lhs_reg, lhs_next;
    status_t                pend_status_reg, pend_status_next;
    logic [COORD_BITS-1:0]  pend_x_reg, pend_x_next;
    out_item_t              out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   wr_en;
    logic [AW-1:0]          rd_addr;
    logic [COORD_BITS-1:0]  rd_x, rd_y;
    logic [OPER_BITS-1:0]   mul_a, mul_b;
    logic [PROD_BITS-1:0]   prod;

    trs_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(in_data.point_index)),
        .wr_x    (in_data.x_value),
        .wr_y    (in_data.y_value),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    trs_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            points_reg    <= PTS_BITS'(2);
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                points_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        idx_reg         <= idx_next;
        rx_reg          <= rx_next;
        ry_reg          <= ry_next;
        f_reg           <= f_next;
        xc_reg          <= xc_next;
        yc_reg          <= yc_next;
        xj_reg          <= xj_next;
        yj_reg          <= yj_next;
        lneg_reg        <= lneg_next;
        dy_neg_reg      <= dy_neg_next;
        dxc_neg_reg     <= dxc_neg_next;
        dy_mag_reg      <= dy_mag_next;
        dxc_mag_reg     <= dxc_mag_next;
        lhs_reg         <= lhs_next;
        pend_status_reg <= pend_status_next;
        pend_x_reg      <= pend_x_next;
        out_reg         <= out_next;
    end

    always_comb
    begin
        int                   pts;
        logic                 hit;
        logic                 rneg;
        logic                 lneg;
        logic                 le;

        pts  = int'(points_reg);
        hit  = 1'b0;
        rneg = 1'b0;
        lneg = 1'b0;
        le   = 1'b0;

        state_next       = state_reg;
        max_next         = max_reg;
        n_next           = n_reg;
        idx_next         = idx_reg;
        rx_next          = rx_reg;
        ry_next          = ry_reg;
        f_next           = f_reg;
        xc_next          = xc_reg;
        yc_next          = yc_reg;
        xj_next          = xj_reg;
        yj_next          = yj_reg;
        lneg_next        = lneg_reg;
        dy_neg_next      = dy_neg_reg;
        dxc_neg_next     = dxc_neg_reg;
        dy_mag_next      = dy_mag_reg;
        dxc_mag_next     = dxc_mag_reg;
        lhs_next         = lhs_reg;
        pend_status_next = pend_status_reg;
        pend_x_next      = pend_x_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        in_ready = 1'b0;
        wr_en    = 1'b0;
        rd_addr  = '0;
        mul_a    = '0;
        mul_b    = '0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.op == OP_LOAD)
                    begin
                        if (int'(in_data.point_index) < TABLE_DEPTH)
                        begin
                            wr_en = 1'b1;
                            if (in_data.point_index == '0 || in_data.y_value > max_reg)
                            begin
                                max_next = in_data.y_value;
                            end
                        end
                        pend_status_next = ST_LOAD_DONE;
                        pend_x_next      = '0;
                        state_next       = S_FINISH;
                    end
                    else
                    begin
                        // clamp the point count to between 2 and the table size
                        if (pts < 2)
                        begin
                            n_next = NW'(2);
                        end
                        else if (pts > TABLE_DEPTH)
                        begin
                            n_next = NW'(TABLE_DEPTH);
                        end
                        else
                        begin
                            n_next = NW'(pts);
                        end
                        rx_next    = in_data.rand_x;
                        ry_next    = in_data.rand_y;
                        rd_addr    = '0;
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                f_next     = rd_x;
                rd_addr    = AW'(n_reg - NW'(1));
                state_next = S_LAST;
            end
            S_LAST:
            begin
                mul_a = OPER_BITS'(rx_reg);
                mul_b = (rd_x >= f_reg) ? OPER_BITS'(rd_x - f_reg) : '0;
                state_next = S_MUL_X;
            end
            S_MUL_X:
            begin
                xc_next    = f_reg + prod[RAND_BITS +: COORD_BITS];
                mul_a      = OPER_BITS'(ry_reg);
                mul_b      = OPER_BITS'(max_reg);
                idx_next   = AW'(n_reg - NW'(2));
                rd_addr    = AW'(n_reg - NW'(2));
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                yc_next    = prod[RAND_BITS +: COORD_BITS];
                rd_addr    = idx_reg;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // downward scan, first entry at or below the candidate wins, else entry zero
                hit = (idx_reg == '0) || (rd_x <= xc_reg);
                if (hit)
                begin
                    xj_next    = rd_x;
                    yj_next    = rd_y;
                    rd_addr    = idx_reg + AW'(1);
                    state_next = S_NEXT;
                end
                else
                begin
                    idx_next = idx_reg - AW'(1);
                    rd_addr  = idx_reg - AW'(1);
                end
            end
            S_NEXT:
            begin
                pend_x_next = xc_reg;
                if (rd_x <= xj_reg)
                begin
                    // segment with no positive width: compare against the weight at its start
                    pend_status_next = (yc_reg <= yj_reg) ? ST_ACCEPT : ST_REJECT;
                    state_next       = S_FINISH;
                end
                else
                begin
                    lneg_next    = yc_reg < yj_reg;
                    mul_a        = (yc_reg >= yj_reg) ? OPER_BITS'(yc_reg - yj_reg)
                                                      : OPER_BITS'(yj_reg - yc_reg);
                    mul_b        = OPER_BITS'(rd_x - xj_reg);
                    dy_neg_next  = rd_y < yj_reg;
                    dy_mag_next  = (rd_y >= yj_reg) ? OPER_BITS'(rd_y - yj_reg)
                                                    : OPER_BITS'(yj_reg - rd_y);
                    dxc_neg_next = xc_reg < xj_reg;
                    dxc_mag_next = (xc_reg >= xj_reg) ? OPER_BITS'(xc_reg - xj_reg)
                                                      : OPER_BITS'(xj_reg - xc_reg);
                    state_next   = S_LHS;
                end
            end
            S_LHS:
            begin
                lhs_next   = prod;
                mul_a      = dy_mag_reg;
                mul_b      = dxc_mag_reg;
                state_next = S_RHS;
            end
            S_RHS:
            begin
                // signed compare of lhs <= rhs from sign and magnitude
                lneg = lneg_reg && (lhs_reg != '0);
                rneg = (prod != '0) && (dy_neg_reg != dxc_neg_reg);
                if (lneg != rneg)
                begin
                    le = lneg;
                end
                else if (lneg)
                begin
                    le = lhs_reg >= prod;
                end
                else
                begin
                    le = lhs_reg <= prod;
                end
                pend_status_next = le ? ST_ACCEPT : ST_REJECT;
                state_next       = S_FINISH;
            end
            S_FINISH:
            begin
                // move the result once the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    out_next.status   = pend_status_reg;
                    out_next.sample_x = pend_x_reg;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> NW'(idx_reg) <= n_reg - NW'(2))
        else $error("segment scan index beyond last segment");

    a_max_reload: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op == OP_LOAD && in_data.point_index == '0
        |=> max_reg == $past(in_data.y_value))
        else $error("maximum weight not restarted by a load at index zero");

    a_load_no_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_LOAD_DONE |-> out_data.sample_x == '0)
        else $error("load result carries a sample value");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && out_valid_reg && !out_ready |=> state_reg == S_FINISH)
        else $error("pending result left before the output slot was free");

endmodule
